// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is held
`define PFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also runs through reset
`define PFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/pfb_pkg.sv -----
package pfb_pkg;

  localparam int MAX_PACKET_LEN   = 64;
  localparam int PACKET_SLOTS     = 16;
  localparam int BYTE_STORE_DEPTH = 1024;

  localparam int SLOT_W = $clog2(PACKET_SLOTS);
  localparam int ADDR_W = $clog2(BYTE_STORE_DEPTH);
  localparam int HELD_W = $clog2(PACKET_SLOTS + 1);
  localparam int USED_W = $clog2(BYTE_STORE_DEPTH + 1);
  localparam int LEN_W  = 7;

  localparam logic [2:0] ST_PUSHED     = 3'd0;
  localparam logic [2:0] ST_TOO_LONG   = 3'd1;
  localparam logic [2:0] ST_SLOTS_FULL = 3'd2;
  localparam logic [2:0] ST_NO_SPACE   = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;
  localparam logic [2:0] ST_POPPED     = 3'd5;

  localparam logic [1:0] CFG_MAX_PACKET_BYTES = 2'd0;
  localparam logic [1:0] CFG_MAX_PACKETS      = 2'd1;
  localparam logic [1:0] CFG_BYTE_CAPACITY    = 2'd2;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       data;
    logic             byte_valid;
    logic [31:0]      pkt_id;
    logic [LEN_W-1:0] length;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [31:0]       pkt_id;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] offset;
  } desc_t;

endpackage

// ----- rtl/core/pfb_out_buf.sv -----
module pfb_out_buf
  import pfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       issue_valid,
  input  res_t       issue_item,
  input  logic [7:0] rd_byte,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_item
);

  logic pend_v_r, pend_v_nxt;
  res_t pend_r;
  logic out_v_r, out_v_nxt;
  res_t out_r, out_nxt;
  logic sk_v_r, sk_v_nxt;
  res_t sk_r, sk_nxt;
  res_t pend_res;
  logic take;
  logic [2:0] occ;

  // byte read issued last cycle lands now
  always_comb begin
    pend_res = pend_r;
    if (!pend_r.byte_valid) begin
      pend_res.data = 8'd0;
    end else begin
      pend_res.data = rd_byte;
    end
  end

  assign take      = out_v_r && out_ready;
  assign occ       = {2'b00, out_v_r} + {2'b00, sk_v_r} + {2'b00, pend_v_r};
  assign room      = occ < (3'd2 + {2'b00, take});
  assign out_valid = out_v_r;
  assign out_item  = out_r;
  assign pend_v_nxt = issue_valid;

  always_comb begin
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    sk_v_nxt  = sk_v_r;
    sk_nxt    = sk_r;
    if (!out_v_r || take) begin
      if (sk_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = sk_r;
        sk_v_nxt  = pend_v_r;
        sk_nxt    = pend_res;
      end else begin
        out_v_nxt = pend_v_r;
        out_nxt   = pend_res;
      end
    end else if (pend_v_r) begin
      sk_v_nxt = 1'b1;
      sk_nxt   = pend_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      sk_v_r   <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      sk_v_r   <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= issue_item;
    out_r  <= out_nxt;
    sk_r   <= sk_nxt;
  end

endmodule

// ----- rtl/core/packet_fifo_with_byte_budget_core.sv -----
// Packet FIFO with a byte budget. Packet bytes live in a 1024-entry byte ring
// memory, and a 16-entry descriptor memory holds id, length and ring offset per
// packet. A push request carries one byte per cycle and is taken every cycle
// while the block is idle and the result buffer has room; only the last byte of
// a packet returns a result (its verdict). A pop request returns n = min(length,
// buffer_size) bytes (one byteless result when n is zero): the descriptor is
// read, then latched, then one byte per cycle is read from the byte memory while
// the result buffer has room. A pop of an empty queue returns a single empty
// result. Results leave through an output register with a skid stage, so new
// requests are still taken while a result waits, as long as the buffer has room.
// The memories need no clearing after reset; configuration must be written
// through the cfg_ port only while the block is idle, which the block does not enforce.
module packet_fifo_with_byte_budget_core
  import pfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // data_byte[7:0], packet_id[39:8], declared_length[71:40], buffer_size[78:72]
  input  logic [79:0] in_tdata,
  // op[0], first_byte[1]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_byte[7:0], out_packet_id[39:8], out_length[46:40]
  output logic [47:0] out_tdata,
  // status[2:0], byte_valid[3]
  output logic [3:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DESC = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]  max_pkt_r;
  logic [4:0]  max_slots_r;
  logic [10:0] byte_cap_r;

  logic [SLOT_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [ADDR_W-1:0] woff_r, woff_nxt;
  logic              open_r, open_nxt;
  logic [1:0]        verdict_r, verdict_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt, plen_r, plen_nxt;
  logic [31:0]       pid_r, pid_nxt;

  logic [6:0]        bufsz_r, bufsz_nxt;
  logic [31:0]       pop_id_r, pop_id_nxt;
  logic [LEN_W-1:0]  pop_len_r, pop_len_nxt, pop_n_r, pop_n_nxt, pop_idx_r, pop_idx_nxt;
  logic [ADDR_W-1:0] pop_off_r, pop_off_nxt;

  logic [7:0] byte_mem [BYTE_STORE_DEPTH];
  logic [7:0] byte_q_r;
  logic              byte_we, byte_re;
  logic [ADDR_W-1:0] byte_waddr, byte_raddr;

  desc_t desc_mem [PACKET_SLOTS];
  desc_t desc_q_r, desc_wdata;
  logic  desc_we, desc_re;

  logic in_op, in_first, acc, room, issue_valid, out_valid;
  logic [7:0]  in_byte;
  logic [31:0] in_pid, in_dlen;
  logic [6:0]  in_bufsz;
  res_t issue_item, out_item;

  logic [6:0]       lim_len;
  logic [4:0]       lim_slots;
  logic [10:0]      lim_cap;
  logic [1:0]       new_verdict, eff_verdict;
  logic             eff_open, store_byte;
  logic [LEN_W-1:0] eff_cnt, eff_len, cnt_new, n_calc;

  assign in_op     = in_tuser[0];
  assign in_first  = in_tuser[1];
  assign in_byte   = in_tdata[7:0];
  assign in_pid    = in_tdata[39:8];
  assign in_dlen   = in_tdata[71:40];
  assign in_bufsz  = in_tdata[78:72];
  assign in_tready = (state_r == S_IDLE) && room;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign lim_len   = (max_pkt_r > 7'(MAX_PACKET_LEN)) ? 7'(MAX_PACKET_LEN) : max_pkt_r;
  assign lim_slots = (max_slots_r > 5'(PACKET_SLOTS)) ? 5'(PACKET_SLOTS) : max_slots_r;
  assign lim_cap   = (byte_cap_r > 11'(BYTE_STORE_DEPTH)) ? 11'(BYTE_STORE_DEPTH) : byte_cap_r;

  always_comb begin
    if (in_dlen > {25'd0, lim_len}) begin
      new_verdict = ST_TOO_LONG[1:0];
    end else if (({1'b0, held_r} + 6'd1) > {1'b0, lim_slots}) begin
      new_verdict = ST_SLOTS_FULL[1:0];
    end else if (({1'b0, used_r} + {5'd0, in_dlen[6:0]}) > {1'b0, lim_cap}) begin
      new_verdict = ST_NO_SPACE[1:0];
    end else begin
      new_verdict = ST_PUSHED[1:0];
    end
  end

  assign eff_open    = in_first || open_r;
  assign eff_verdict = in_first ? new_verdict : verdict_r;
  assign eff_cnt     = in_first ? '0 : cnt_r;
  assign eff_len     = in_first ? in_dlen[LEN_W-1:0] : plen_r;
  assign store_byte  = acc && !in_op && eff_open && (eff_verdict == ST_PUSHED[1:0])
                       && (eff_cnt < eff_len);
  assign cnt_new     = eff_cnt + {{(LEN_W-1){1'b0}}, store_byte};
  assign n_calc      = (desc_q_r.length < bufsz_r) ? desc_q_r.length : bufsz_r;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    held_nxt    = held_r;
    used_nxt    = used_r;
    woff_nxt    = woff_r;
    open_nxt    = open_r;
    verdict_nxt = verdict_r;
    cnt_nxt     = cnt_r;
    plen_nxt    = plen_r;
    pid_nxt     = pid_r;
    bufsz_nxt   = bufsz_r;
    pop_id_nxt  = pop_id_r;
    pop_len_nxt = pop_len_r;
    pop_n_nxt   = pop_n_r;
    pop_idx_nxt = pop_idx_r;
    pop_off_nxt = pop_off_r;
    byte_we     = store_byte;
    byte_waddr  = woff_r + ADDR_W'(eff_cnt);
    byte_re     = 1'b0;
    byte_raddr  = pop_off_r + ADDR_W'(pop_idx_r);
    desc_we     = 1'b0;
    desc_re     = 1'b0;
    desc_wdata  = '{pkt_id: pid_r, length: cnt_new, offset: woff_r};
    issue_valid = 1'b0;
    issue_item  = '{status: ST_EMPTY, data: 8'd0, byte_valid: 1'b0, pkt_id: 32'd0,
                    length: '0, last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (acc && in_op) begin
          if (held_r == '0) begin
            issue_valid = 1'b1;
          end else begin
            desc_re   = 1'b1;
            bufsz_nxt = in_bufsz;
            state_nxt = S_DESC;
          end
        end else if (acc && eff_open) begin
          open_nxt    = !in_tlast;
          verdict_nxt = eff_verdict;
          cnt_nxt     = cnt_new;
          plen_nxt    = eff_len;
          if (in_first) begin
            pid_nxt = in_pid;
          end
          if (in_tlast) begin
            issue_valid       = 1'b1;
            issue_item.status = {1'b0, eff_verdict};
            if (eff_verdict == ST_PUSHED[1:0]) begin
              desc_we           = 1'b1;
              desc_wdata.pkt_id = in_first ? in_pid : pid_r;
              tail_nxt          = tail_r + 1'b1;
              held_nxt          = held_r + 1'b1;
              used_nxt          = used_r + USED_W'(cnt_new);
              woff_nxt          = woff_r + ADDR_W'(cnt_new);
            end
          end
        end
      end
      S_DESC: begin
        pop_id_nxt  = desc_q_r.pkt_id;
        pop_len_nxt = desc_q_r.length;
        pop_off_nxt = desc_q_r.offset;
        pop_n_nxt   = n_calc;
        pop_idx_nxt = '0;
        head_nxt    = head_r + 1'b1;
        held_nxt    = held_r - 1'b1;
        used_nxt    = (used_r >= USED_W'(desc_q_r.length))
                      ? used_r - USED_W'(desc_q_r.length) : '0;
        state_nxt   = S_POP;
      end
      S_POP: begin
        if (room) begin
          issue_valid       = 1'b1;
          issue_item.status = ST_POPPED;
          issue_item.pkt_id = pop_id_r;
          issue_item.length = pop_len_r;
          if (pop_n_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            byte_re               = 1'b1;
            issue_item.byte_valid = 1'b1;
            issue_item.last       = (pop_idx_r + 1'b1) == pop_n_r;
            pop_idx_nxt           = pop_idx_r + 1'b1;
            if ((pop_idx_r + 1'b1) == pop_n_r) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_pkt_r   <= 7'd64;
      max_slots_r <= 5'd16;
      byte_cap_r  <= 11'd1024;
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      used_r      <= '0;
      woff_r      <= '0;
      open_r      <= 1'b0;
      verdict_r   <= ST_PUSHED[1:0];
      cnt_r       <= '0;
      plen_r      <= '0;
      pid_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      held_r    <= held_nxt;
      used_r    <= used_nxt;
      woff_r    <= woff_nxt;
      open_r    <= open_nxt;
      verdict_r <= verdict_nxt;
      cnt_r     <= cnt_nxt;
      plen_r    <= plen_nxt;
      pid_r     <= pid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_PACKET_BYTES: max_pkt_r   <= cfg_data[6:0];
          CFG_MAX_PACKETS:      max_slots_r <= cfg_data[4:0];
          CFG_BYTE_CAPACITY:    byte_cap_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    bufsz_r   <= bufsz_nxt;
    pop_id_r  <= pop_id_nxt;
    pop_len_r <= pop_len_nxt;
    pop_n_r   <= pop_n_nxt;
    pop_idx_r <= pop_idx_nxt;
    pop_off_r <= pop_off_nxt;
  end

  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[byte_waddr] <= in_byte;
    end
    if (byte_re) begin
      byte_q_r <= byte_mem[byte_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[tail_r] <= desc_wdata;
    end
    if (desc_re) begin
      desc_q_r <= desc_mem[head_r];
    end
  end

  pfb_out_buf u_out_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue_valid (issue_valid),
    .issue_item  (issue_item),
    .rd_byte     (byte_q_r),
    .room        (room),
    .out_valid   (out_valid),
    .out_ready   (out_tready),
    .out_item    (out_item)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = {1'b0, out_item.length, out_item.pkt_id, out_item.data};
  assign out_tuser  = {out_item.byte_valid, out_item.status};
  assign out_tlast  = out_item.last;

endmodule

// ----- rtl/core/pfb_checker.sv -----
`include "assert_macros.svh"

module pfb_checker
  import pfb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);

  logic        stalled;
  logic [52:0] out_word;

  assign stalled  = out_tvalid && !out_tready;
  assign out_word = {out_tlast, out_tuser, out_tdata};

  `PFB_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid, "result valid right after reset")
  `PFB_ASSERT(a_hold, stalled |=> out_tvalid && $stable(out_word), "stalled result changed")
  `PFB_ASSERT(a_byte_pop, out_tvalid && out_tuser[3] |-> out_tuser[2:0] == ST_POPPED, "payload byte outside a pop")
  `PFB_ASSERT(a_single_end, out_tvalid && !out_tuser[3] |-> out_tlast, "byteless result not closing its run")
  `PFB_ASSERT(a_len_range, out_tvalid |-> out_tdata[46:40] <= 7'(MAX_PACKET_LEN), "packet length out of range")

endmodule

bind packet_fifo_with_byte_budget_core pfb_checker u_pfb_checker (.*);

// ----- bench/packet_fifo_with_byte_budget_core_tb.sv -----
module packet_fifo_with_byte_budget_core_tb;
  import pfb_pkg::*;

  localparam logic       OP_PUSH       = 1'b0;
  localparam logic       OP_POP        = 1'b1;
  localparam logic [1:0] CFG_SPARE     = 2'd3;
  localparam int         SETTLE_CYCLES = 20;
  localparam int         DRAIN_CYCLES  = 40;
  localparam int         LONG_HOLD     = 400;
  localparam int         QUIET_LIMIT   = 4000;

  typedef struct packed {
    logic        op;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [31:0] id;
    logic [31:0] dlen;
    logic [6:0]  bufsz;
  } req_t;

  typedef struct packed {
    req_t       r;
    logic       typed;
    logic [2:0] status;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  // mirror of the packet FIFO
  logic [7:0]       ring_bytes [BYTE_STORE_DEPTH];
  logic [31:0]      slot_id    [PACKET_SLOTS];
  logic [LEN_W-1:0] slot_len   [PACKET_SLOTS];
  int unsigned      slot_off   [PACKET_SLOTS];
  int unsigned      rd_slot, wr_slot, pkts_held, bytes_held, wr_ptr;
  int unsigned      lim_bytes, lim_pkts, lim_cap;
  logic             pkt_open;
  logic [2:0]       open_verdict;
  logic [31:0]      open_id;
  int unsigned      open_len, open_fill;

  res_t result_backlog[$];

  int  error_count, results_checked, requests_taken, commits, refusals, empties;
  int  quiet_cycles;
  int  holds_asked, holds_done;
  bit  calm;

  packet_fifo_with_byte_budget_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    error_count++;
    if (error_count <= 60)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic advance_fifo(input req_t r);
    res_t        res;
    int unsigned n, lim_len, lim_slots, lim_room;
    res = '0;
    if (r.op == OP_POP) begin
      if (pkts_held == 0) begin
        res.status = ST_EMPTY;
        res.last   = 1'b1;
        result_backlog.push_back(res);
        empties++;
        return;
      end
      n = 32'((slot_len[rd_slot] < r.bufsz) ? slot_len[rd_slot] : r.bufsz);
      res.status = ST_POPPED;
      res.pkt_id = slot_id[rd_slot];
      res.length = slot_len[rd_slot];
      if (n == 0) begin
        res.last = 1'b1;
        result_backlog.push_back(res);
      end
      for (int i = 0; i < n; i++) begin
        res.data       = ring_bytes[(slot_off[rd_slot] + i) % BYTE_STORE_DEPTH];
        res.byte_valid = 1'b1;
        res.last       = (i == n - 1);
        result_backlog.push_back(res);
      end
      bytes_held = (bytes_held >= slot_len[rd_slot]) ? bytes_held - slot_len[rd_slot] : 0;
      rd_slot    = (rd_slot + 1) % PACKET_SLOTS;
      pkts_held--;
      return;
    end
    if (r.first) begin
      lim_len   = (lim_bytes < MAX_PACKET_LEN) ? lim_bytes : MAX_PACKET_LEN;
      lim_slots = (lim_pkts < PACKET_SLOTS) ? lim_pkts : PACKET_SLOTS;
      lim_room  = (lim_cap < BYTE_STORE_DEPTH) ? lim_cap : BYTE_STORE_DEPTH;
      pkt_open  = 1'b1;
      open_fill = 0;
      open_id   = r.id;
      open_len  = 32'(r.dlen[LEN_W-1:0]);
      if (r.dlen > lim_len)
        open_verdict = ST_TOO_LONG;
      else if (pkts_held + 1 > lim_slots)
        open_verdict = ST_SLOTS_FULL;
      else if (bytes_held + r.dlen > lim_room)
        open_verdict = ST_NO_SPACE;
      else
        open_verdict = ST_PUSHED;
    end
    if (!pkt_open) return;
    if (open_verdict == ST_PUSHED && open_fill < open_len) begin
      ring_bytes[(wr_ptr + open_fill) % BYTE_STORE_DEPTH] = r.data;
      open_fill++;
    end
    if (!r.last) return;
    pkt_open = 1'b0;
    if (open_verdict == ST_PUSHED) begin
      slot_id[wr_slot]  = open_id;
      slot_len[wr_slot] = LEN_W'(open_fill);
      slot_off[wr_slot] = wr_ptr;
      wr_slot    = (wr_slot + 1) % PACKET_SLOTS;
      pkts_held++;
      bytes_held += open_fill;
      wr_ptr     = (wr_ptr + open_fill) % BYTE_STORE_DEPTH;
      commits++;
    end else begin
      refusals++;
    end
    res.status = open_verdict;
    res.last   = 1'b1;
    result_backlog.push_back(res);
  endtask

  function automatic req_t random_req();
    req_t r;
    r.op    = 1'($urandom_range(0, 1));
    r.data  = 8'($urandom());
    r.first = 1'($urandom_range(0, 1));
    r.last  = 1'($urandom_range(0, 1));
    r.id    = $urandom();
    r.dlen  = $urandom();
    r.bufsz = 7'($urandom_range(0, 127));
    return r;
  endfunction

  function automatic row_t step_row(input logic op, input logic [7:0] data,
                                    input logic first, input logic last,
                                    input logic [31:0] id, input logic [31:0] dlen,
                                    input logic [6:0] bufsz, input logic typed,
                                    input logic [2:0] status);
    row_t row;
    row.r      = '{op, data, first, last, id, dlen, bufsz};
    row.typed  = typed;
    row.status = status;
    return row;
  endfunction

  task automatic offer(input req_t r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, r.bufsz, r.dlen, r.id, r.data};
    in_tuser  <= {r.first, r.op};
    in_tlast  <= r.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_fifo(r);
    requests_taken++;
  endtask

  // close any open packet, wait for every result, then let the block go quiet
  task automatic settle(input int cycles);
    req_t r;
    if (pkt_open) begin
      r       = random_req();
      r.op    = OP_PUSH;
      r.first = 1'b0;
      r.last  = 1'b1;
      offer(r);
    end
    in_tvalid <= 1'b0;
    while (result_backlog.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAX_PACKET_BYTES: lim_bytes = 32'(val[6:0]);
      CFG_MAX_PACKETS:      lim_pkts  = 32'(val[4:0]);
      CFG_BYTE_CAPACITY:    lim_cap   = 32'(val);
      default: ;
    endcase
  endtask

  task automatic program_limits(input logic [10:0] pkt_bytes, input logic [10:0] pkts,
                                input logic [10:0] room);
    write_reg(CFG_MAX_PACKET_BYTES, pkt_bytes);
    write_reg(CFG_MAX_PACKETS, pkts);
    write_reg(CFG_BYTE_CAPACITY, room);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_traffic(input int n_items, input int len_cap);
    req_t        r, p;
    logic [31:0] plen;
    int          done_items, pick, items;
    bit          abandon;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(0, 99);
      r    = random_req();
      if (pick < 30) begin
        r.op = OP_POP;
        if ($urandom_range(0, 3) != 0) r.bufsz = 7'd64;
        offer(r);
        done_items++;
      end else if (pick < 36) begin
        if (!pkt_open) begin
          r.op    = OP_PUSH;
          r.first = 1'b0;
          offer(r);
          done_items++;
        end
      end else begin
        case ($urandom_range(0, 9))
          0:       plen = $urandom();
          1:       plen = len_cap + $urandom_range(1, 2);
          2:       plen = len_cap;
          default: plen = $urandom_range(0, len_cap);
        endcase
        if (plen > MAX_PACKET_LEN) items = $urandom_range(1, 6);
        else if (plen == 0)        items = 1;
        else                       items = plen;
        case ($urandom_range(0, 9))
          0:       items = $urandom_range(1, items);
          1:       items = items + $urandom_range(1, 3);
          default: ;
        endcase
        abandon = ($urandom_range(0, 19) == 0);
        for (int k = 0; k < items; k++) begin
          r       = random_req();
          r.op    = OP_PUSH;
          r.first = (k == 0);
          r.last  = (k == items - 1) && !abandon;
          if (k == 0) r.dlen = plen;
          offer(r);
          done_items++;
          if (!r.last && $urandom_range(0, 19) == 0) begin
            p    = random_req();
            p.op = OP_POP;
            offer(p);
            done_items++;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.data       = out_tdata[7:0];
      got.pkt_id     = out_tdata[39:8];
      got.length     = out_tdata[46:40];
      got.status     = out_tuser[2:0];
      got.byte_valid = out_tuser[3];
      got.last       = out_tlast;
      results_checked++;
      if (result_backlog.size() == 0) begin
        note_mismatch("unrequested result", got, 0);
      end else begin
        want = result_backlog.pop_front();
        if (got.status !== want.status)         note_mismatch("status", got.status, want.status);
        if (got.data !== want.data)             note_mismatch("out_byte", got.data, want.data);
        if (got.byte_valid !== want.byte_valid)
          note_mismatch("byte_valid", got.byte_valid, want.byte_valid);
        if (got.pkt_id !== want.pkt_id)         note_mismatch("packet id", got.pkt_id, want.pkt_id);
        if (got.length !== want.length)         note_mismatch("length", got.length, want.length);
        if (got.last !== want.last)             note_mismatch("end of run", got.last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[%0t] watchdog: no progress, %0d results outstanding", $time,
               result_backlog.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : result_sink
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    row_t plan[$];
    res_t typed_res;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rd_slot = 0; wr_slot = 0; pkts_held = 0; bytes_held = 0; wr_ptr = 0;
    lim_bytes = 64; lim_pkts = 16; lim_cap = 1024;
    pkt_open = 1'b0; open_verdict = ST_PUSHED; open_fill = 0; open_len = 0; open_id = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    plan.push_back(step_row(OP_POP,  8'h00, 0, 0, 32'h0,        32'h0,        7'd64,  1, ST_EMPTY));
    // zero-length packet, all-ones id
    plan.push_back(step_row(OP_PUSH, 8'hFF, 1, 1, 32'hFFFFFFFF, 32'h0,        7'd0,   1, ST_PUSHED));
    plan.push_back(step_row(OP_POP,  8'h00, 0, 0, 32'h0,        32'h0,        7'd127, 0, ST_POPPED));
    plan.push_back(step_row(OP_PUSH, 8'h00, 1, 0, 32'h0,        32'd65,       7'd0,   0, ST_PUSHED));
    plan.push_back(step_row(OP_PUSH, 8'h5A, 0, 1, 32'h0,        32'h0,        7'd0,   1, ST_TOO_LONG));
    plan.push_back(step_row(OP_PUSH, 8'h00, 1, 1, 32'h0,        32'hFFFFFFFF, 7'd0,   1, ST_TOO_LONG));
    plan.push_back(step_row(OP_PUSH, 8'h00, 1, 0, 32'h12345678, 32'd3,        7'd0,   0, ST_PUSHED));
    plan.push_back(step_row(OP_PUSH, 8'hFF, 0, 0, 32'h0,        32'h0,        7'd0,   0, ST_PUSHED));
    plan.push_back(step_row(OP_PUSH, 8'hA5, 0, 1, 32'h0,        32'h0,        7'd0,   1, ST_PUSHED));
    // stray closing byte with nothing open
    plan.push_back(step_row(OP_PUSH, 8'h3C, 0, 1, 32'h0,        32'h0,        7'd0,   0, ST_PUSHED));
    // short packet
    plan.push_back(step_row(OP_PUSH, 8'h11, 1, 0, 32'hCAFE0001, 32'd4,        7'd0,   0, ST_PUSHED));
    plan.push_back(step_row(OP_PUSH, 8'h22, 0, 1, 32'h0,        32'h0,        7'd0,   1, ST_PUSHED));
    // restart drops the open packet
    plan.push_back(step_row(OP_PUSH, 8'h33, 1, 0, 32'h0BAD0002, 32'd2,        7'd0,   0, ST_PUSHED));
    plan.push_back(step_row(OP_PUSH, 8'h44, 1, 1, 32'h00000003, 32'd1,        7'd0,   1, ST_PUSHED));
    // bytes past the declared length are dropped
    plan.push_back(step_row(OP_PUSH, 8'h55, 1, 0, 32'h00000004, 32'd1,        7'd0,   0, ST_PUSHED));
    plan.push_back(step_row(OP_PUSH, 8'h66, 0, 0, 32'h0,        32'h0,        7'd0,   0, ST_PUSHED));
    plan.push_back(step_row(OP_PUSH, 8'h77, 0, 1, 32'h0,        32'h0,        7'd0,   1, ST_PUSHED));
    plan.push_back(step_row(OP_POP,  8'h00, 0, 0, 32'h0,        32'h0,        7'd0,   0, ST_POPPED));
    plan.push_back(step_row(OP_PUSH, 8'h80, 1, 0, 32'hDEADBEEF, 32'd64,       7'd0,   0, ST_PUSHED));
    // pop while a push is open
    plan.push_back(step_row(OP_POP,  8'h00, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 7'd127, 0, ST_POPPED));
    plan.push_back(step_row(OP_PUSH, 8'h01, 0, 1, 32'h0,        32'h0,        7'd0,   1, ST_PUSHED));
    plan.push_back(step_row(OP_POP,  8'h00, 0, 0, 32'h0,        32'h0,        7'd1,   0, ST_POPPED));
    plan.push_back(step_row(OP_POP,  8'h00, 0, 0, 32'h0,        32'h0,        7'd64,  0, ST_POPPED));
    plan.push_back(step_row(OP_POP,  8'h00, 0, 0, 32'h0,        32'h0,        7'd64,  0, ST_POPPED));
    plan.push_back(step_row(OP_POP,  8'hFF, 1, 1, 32'h0,        32'h0,        7'd64,  1, ST_EMPTY));

    foreach (plan[i]) begin
      offer(plan[i].r);
      if (plan[i].typed) begin
        typed_res        = '0;
        typed_res.status = plan[i].status;
        typed_res.last   = 1'b1;
        void'(result_backlog.pop_back());
        result_backlog.push_back(typed_res);
      end
    end
    settle(SETTLE_CYCLES);

    // all-ones writes: every limit clamps to the build size
    program_limits(11'h7FF, 11'h7FF, 11'h7FF);
    holds_asked++;
    random_traffic(30, 64);
    settle(SETTLE_CYCLES);

    write_reg(CFG_SPARE, 11'h7FF);
    program_limits(11'd0, 11'd0, 11'd0);
    random_traffic(12, 4);
    settle(SETTLE_CYCLES);

    program_limits(11'd8, 11'd3, 11'd20);
    random_traffic(40, 10);
    settle(SETTLE_CYCLES);

    program_limits(11'd64, 11'd16, 11'd1024);
    random_traffic(25, 64);
    calm = 1'b1;
    random_traffic(20, 64);
    settle(DRAIN_CYCLES);

    $display("Covered %0d requests and %0d results: %0d packets stored, %0d refused, %0d empty pops.",
             requests_taken, results_checked, commits, refusals, empties);
    $display("Limits run through reset values, all-ones, all-zero, tight and full-size settings.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
